@@ rtl/blf_pkg.sv @@
`default_nettype none

package blf_pkg;

  // event codes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  // register indexes on the apb port
  typedef enum logic [1:0] {
    REG_MAX_BRIGHTNESS = 2'd0,
    REG_TIMEOUT_SELECT = 2'd1,
    REG_PWM_PERIOD     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // fade and level constants
  localparam logic [4:0] FADE_STEPS = 5'd20;
  localparam logic [7:0] FULL_LEVEL = 8'd10;

  // reset values of the configuration registers
  localparam logic [7:0]  MAX_BRIGHTNESS_RST = 8'd10;
  localparam logic [2:0]  TIMEOUT_SELECT_RST = 3'd1;
  localparam logic [15:0] PWM_PERIOD_RST     = 16'd1023;

  // reciprocal constants for division by constants
  // x / 20 for x < 8192: (x * 6554) >> 17
  localparam logic [15:0] DIV20_MUL   = 16'd6554;
  localparam int          DIV20_SHIFT = 17;
  // x / 10 for 16-bit x: (x * 52429) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  // x / 10 for x < 1024: (x * 205) >> 11
  localparam logic [15:0] DIV10S_MUL   = 16'd205;
  localparam int          DIV10S_SHIFT = 11;

  typedef struct packed {
    logic [7:0]  max_brightness;
    logic [2:0]  timeout_select;
    logic [15:0] pwm_period;
  } cfg_t;

  // off-countdown in half seconds per timeout choice
  function automatic logic [8:0] countdown_of(input logic [2:0] sel);
    logic [8:0] val;
    unique case (sel)
      3'd1:    val = 9'd11;
      3'd2:    val = 9'd21;
      3'd3:    val = 9'd41;
      3'd4:    val = 9'd121;
      3'd5:    val = 9'd241;
      3'd6:    val = 9'd481;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/blf_if.sv @@
`default_nettype none

// event channel
interface blf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] new_level;

  modport source (output valid, output opcode, output new_level, input ready);
  modport sink (input valid, input opcode, input new_level, output ready);
endinterface

// result channel
interface blf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pwm_compare;
  logic        light_is_on;
  logic [7:0]  level_now;
  logic [8:0]  countdown_load;
  logic        countdown_load_valid;

  modport source (output valid, output pwm_compare, output light_is_on, output level_now,
                  output countdown_load, output countdown_load_valid, input ready);
  modport sink (input valid, input pwm_compare, input light_is_on, input level_now,
                input countdown_load, input countdown_load_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/blf_regs.sv @@
`default_nettype none

module blf_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [blf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [blf_pkg::DATA_W-1:0] pwdata,
  output logic      [blf_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output blf_pkg::cfg_t                   cfg
);
  import blf_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_brightness <= MAX_BRIGHTNESS_RST;
      cfg.timeout_select <= TIMEOUT_SELECT_RST;
      cfg.pwm_period     <= PWM_PERIOD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_BRIGHTNESS: cfg.max_brightness <= pwdata[7:0];
        REG_TIMEOUT_SELECT: cfg.timeout_select <= pwdata[2:0];
        REG_PWM_PERIOD:     cfg.pwm_period     <= pwdata[15:0];
        REG_UNUSED:         ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MAX_BRIGHTNESS: prdata = {24'd0, cfg.max_brightness};
      REG_TIMEOUT_SELECT: prdata = {29'd0, cfg.timeout_select};
      REG_PWM_PERIOD:     prdata = {16'd0, cfg.pwm_period};
      REG_UNUSED:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/blf_mul.sv @@
`default_nettype none

module blf_mul (
  input  wire logic        clk,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [31:0] prod
);

  // registered 16x16 product, one result per cycle
  always_ff @(posedge clk) begin
    prod <= 32'(a) * 32'(b);
  end

endmodule

`default_nettype wire

@@ rtl/backlight_fade_controller.sv @@
// sequence: an event is taken in S_IDLE and runs S_CMP, then S_DONE at or above full
// level, or S_CMP_Q, S_CMP_R, S_CMP_F and S_CMP_E before S_DONE below it; a tick that
// steps a fade runs S_MIX_A to S_MIX_D first; S_DONE waits for a free result register.
// only an idle sequencer takes events; all products use the one shared 16x16 multiplier
// reset: synchronous rst clears the fade state and level, sets the registers to
// their defaults and empties the result register; no clearing pass is needed
`default_nettype none

module backlight_fade_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  blf_in_if.sink                          events,
  blf_out_if.source                       results,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [blf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [blf_pkg::DATA_W-1:0] pwdata,
  output logic      [blf_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import blf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX_A,
    S_MIX_B,
    S_MIX_S,
    S_MIX_D,
    S_CMP,
    S_CMP_Q,
    S_CMP_R,
    S_CMP_F,
    S_CMP_E,
    S_DONE
  } state_t;

  state_t      state;
  cfg_t        cfg;

  logic [7:0]  target_level;
  logic [7:0]  fade_from_level;
  logic [4:0]  fade_step;
  logic        fade_active;
  logic [7:0]  applied_level;
  logic        on_flag;

  logic [15:0] acc;
  logic [3:0]  rem_r;
  logic [15:0] cmp_r;
  logic [8:0]  load_r;
  logic        load_valid_r;

  logic        out_valid;
  logic [15:0] out_compare;
  logic        out_on;
  logic [7:0]  out_level;
  logic [8:0]  out_load;
  logic        out_load_valid;

  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod;

  logic [4:0]  step_inc;
  logic [12:0] quot10;
  logic [15:0] rem_full;
  logic [12:0] mix_sum;
  op_t         op;

  // configuration registers
  blf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiplier
  blf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign op       = op_t'(events.opcode);
  assign step_inc = fade_step + 5'd1;
  assign quot10   = prod[DIV10_SHIFT +: 13];
  assign rem_full = cfg.pwm_period - ({quot10, 3'b000} + {2'b00, quot10, 1'b0});
  assign mix_sum  = acc[12:0] + prod[12:0];

  // operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MIX_A: begin
        mul_a = {8'd0, fade_from_level};
        mul_b = {11'd0, FADE_STEPS - fade_step};
      end
      S_MIX_B: begin
        mul_a = {8'd0, target_level};
        mul_b = {11'd0, fade_step};
      end
      S_MIX_S: begin
        mul_a = {3'd0, mix_sum};
        mul_b = DIV20_MUL;
      end
      S_CMP: begin
        mul_a = cfg.pwm_period;
        mul_b = DIV10_MUL;
      end
      S_CMP_Q: begin
        mul_a = {8'd0, applied_level};
        mul_b = {3'd0, quot10};
      end
      S_CMP_R: begin
        mul_a = {8'd0, applied_level};
        mul_b = {12'd0, rem_r};
      end
      S_CMP_F: begin
        mul_a = {9'd0, prod[6:0]};
        mul_b = DIV10S_MUL;
      end
      S_IDLE, S_MIX_D, S_CMP_E, S_DONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer, fade state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      target_level    <= '0;
      fade_from_level <= '0;
      fade_step       <= '0;
      fade_active     <= 1'b0;
      applied_level   <= '0;
      on_flag         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && results.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (events.valid) begin
            unique case (op)
              OP_TICK: begin
                load_r       <= '0;
                load_valid_r <= 1'b0;
                if (fade_active && target_level != fade_from_level &&
                    step_inc < FADE_STEPS) begin
                  // intermediate fade step goes through the mixer
                  fade_step <= step_inc;
                  state     <= S_MIX_A;
                end else begin
                  state <= S_CMP;
                  if (fade_active) begin
                    applied_level <= target_level;
                    on_flag       <= (target_level != '0);
                    fade_active   <= 1'b0;
                    if (target_level != fade_from_level) begin
                      fade_step       <= '0;
                      fade_from_level <= target_level;
                    end
                  end
                end
              end
              OP_ON, OP_OFF: begin
                load_valid_r <= 1'b1;
                state        <= S_CMP;
                if (op == OP_OFF || cfg.timeout_select == '0) begin
                  // start fade out from the present level
                  target_level    <= '0;
                  fade_from_level <= applied_level;
                  fade_step       <= '0;
                  fade_active     <= 1'b1;
                  load_r          <= '0;
                end else begin
                  target_level    <= cfg.max_brightness;
                  fade_from_level <= cfg.max_brightness;
                  fade_step       <= '0;
                  fade_active     <= 1'b0;
                  applied_level   <= cfg.max_brightness;
                  on_flag         <= (cfg.max_brightness != '0);
                  load_r          <= countdown_of(cfg.timeout_select);
                end
              end
              OP_SET: begin
                load_r        <= '0;
                load_valid_r  <= 1'b0;
                state         <= S_CMP;
                fade_active   <= 1'b0;
                fade_step     <= '0;
                target_level  <= events.new_level;
                applied_level <= events.new_level;
                on_flag       <= (events.new_level != '0);
              end
            endcase
          end
        end
        // from * (steps - step) is being formed
        S_MIX_A: state <= S_MIX_B;
        S_MIX_B: begin
          acc   <= prod[15:0];
          state <= S_MIX_S;
        end
        S_MIX_S: state <= S_MIX_D;
        // mixed sum divided by the step count
        S_MIX_D: begin
          applied_level <= prod[DIV20_SHIFT +: 8];
          on_flag       <= (prod[DIV20_SHIFT +: 8] != '0);
          state         <= S_CMP;
        end
        S_CMP: begin
          if (applied_level >= FULL_LEVEL) begin
            cmp_r <= cfg.pwm_period;
            state <= S_DONE;
          end else begin
            state <= S_CMP_Q;
          end
        end
        // period split into quotient and remainder by ten
        S_CMP_Q: begin
          rem_r <= rem_full[3:0];
          state <= S_CMP_R;
        end
        S_CMP_R: begin
          acc   <= prod[15:0];
          state <= S_CMP_F;
        end
        S_CMP_F: state <= S_CMP_E;
        S_CMP_E: begin
          cmp_r <= acc + {12'd0, prod[DIV10S_SHIFT +: 4]};
          state <= S_DONE;
        end
        // hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_valid      <= 1'b1;
            out_compare    <= cmp_r;
            out_on         <= on_flag;
            out_level      <= applied_level;
            out_load       <= load_r;
            out_load_valid <= load_valid_r;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign events.ready                 = (state == S_IDLE);
  assign results.valid                = out_valid;
  assign results.pwm_compare          = out_compare;
  assign results.light_is_on          = out_on;
  assign results.level_now            = out_level;
  assign results.countdown_load       = out_load;
  assign results.countdown_load_valid = out_load_valid;

  // a fade always runs down to zero
  a_fade_target: assert property (@(posedge clk) disable iff (rst)
    fade_active |-> (target_level == '0))
    else $error("fade active with nonzero target");

  // fade step never reaches the step count
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    fade_step < FADE_STEPS)
    else $error("fade step out of range");

  // on flag tracks the applied level
  a_on_flag: assert property (@(posedge clk) disable iff (rst)
    on_flag == (applied_level != '0))
    else $error("on flag disagrees with applied level");

  // a finished result reaches the output register in the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || results.ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

  // the scaled compare path only runs for levels below full
  a_cmp_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP_Q) |-> (applied_level < FULL_LEVEL))
    else $error("scaled compare taken at full level");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import blf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  // off-countdown per timeout choice, in half seconds
  localparam logic [8:0] HOLD_HALF_SECONDS [8] = '{9'd0, 9'd11, 9'd21, 9'd41,
                                                   9'd121, 9'd241, 9'd481, 9'd0};

  typedef struct packed {
    logic [15:0] pwm_compare;
    logic        light_is_on;
    logic [7:0]  level_now;
    logic [8:0]  countdown_load;
    logic        countdown_load_valid;
  } light_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  blf_in_if ev_if ();
  blf_out_if res_if ();

  backlight_fade_controller DUT (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted register contents
  logic [7:0]  cfg_max_level;
  logic [2:0]  cfg_timeout;
  logic [15:0] cfg_period;

  // predicted fade and level state
  logic [7:0] fade_target;
  logic [7:0] fade_origin;
  logic [4:0] fade_pos;
  logic       fading;
  logic [7:0] level_applied;
  logic       lamp_on;

  light_result_t pending_results[$];
  light_result_t due;
  int fails;
  int events_sent;
  int quiet_cycles;

  // sender pacing
  bit gaps_on;
  bit offering;
  int burst_left;

  // receiver pacing
  int stall_pct;
  int holdoff_req;
  int holdoff_left;
  int run_left;
  bit run_stalled;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // fade-out starts from whatever level is applied now
  function automatic void begin_fade_out();
    fade_target = 8'd0;
    fade_origin = level_applied;
    fade_pos    = 5'd0;
    fading      = 1'b1;
  endfunction

  // expected result of one event; advances the predicted state
  function automatic light_result_t predict_backlight(input op_t op, input logic [7:0] lvl);
    light_result_t r;
    int mix;
    r = '0;
    case (op)
      OP_TICK: begin
        if (fading) begin
          if (fade_target == fade_origin) begin
            level_applied = fade_target;
            fading = 1'b0;
          end else begin
            fade_pos = fade_pos + 5'd1;
            if (fade_pos >= FADE_STEPS) begin
              level_applied = fade_target;
              fading = 1'b0;
              fade_pos = 5'd0;
              fade_origin = fade_target;
            end else begin
              mix = (int'(fade_origin) * (int'(FADE_STEPS) - int'(fade_pos))
                     + int'(fade_target) * int'(fade_pos)) / int'(FADE_STEPS);
              level_applied = 8'(mix);
            end
          end
        end
      end
      OP_ON: begin
        if (cfg_timeout == 3'd0) begin
          begin_fade_out();
        end else begin
          fade_target = cfg_max_level;
          fade_origin = cfg_max_level;
          fade_pos = 5'd0;
          fading = 1'b0;
          level_applied = cfg_max_level;
          r.countdown_load = HOLD_HALF_SECONDS[cfg_timeout];
        end
        r.countdown_load_valid = 1'b1;
      end
      OP_OFF: begin
        begin_fade_out();
        r.countdown_load_valid = 1'b1;
      end
      default: begin
        fading = 1'b0;
        fade_pos = 5'd0;
        fade_target = lvl;
        level_applied = lvl;
      end
    endcase
    lamp_on = (level_applied != 8'd0);
    if (level_applied >= FULL_LEVEL)
      r.pwm_compare = cfg_period;
    else
      r.pwm_compare = 16'((32'(level_applied) * 32'(cfg_period)) / 32'(FULL_LEVEL));
    r.light_is_on = lamp_on;
    r.level_now = level_applied;
    return r;
  endfunction

  // offer one event; returns at a falling edge after the transaction
  task automatic send_event(input op_t op, input logic [7:0] lvl);
    ev_if.valid <= 1'b1;
    ev_if.opcode <= op;
    ev_if.new_level <= lvl;
    offering = 1'b1;
    do @(posedge clk); while (!ev_if.ready);
    pending_results.push_back(predict_backlight(op, lvl));
    events_sent++;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        ev_if.valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(8, 1)) @(negedge clk);
        burst_left = $urandom_range(16, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_event();
    send_event(op_t'($urandom_range(3)), 8'($urandom()));
  endtask

  // lower valid and wait until every expected result has come
  task automatic wait_drained();
    if (offering) begin
      ev_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] predicted_reg(input reg_idx_t idx);
    case (idx)
      REG_MAX_BRIGHTNESS: return 32'(cfg_max_level);
      REG_TIMEOUT_SELECT: return 32'(cfg_timeout);
      REG_PWM_PERIOD:     return 32'(cfg_period);
      default:            return 32'd0;
    endcase
  endfunction

  // apb read, compared with the predicted register
  task automatic reg_check(input reg_idx_t idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(int'(idx) * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== predicted_reg(idx)) begin
      $error("register %s: expected %0d, actual %0d", idx.name(), predicted_reg(idx), got);
      fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb write with junk above the register width, then read back
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_MAX_BRIGHTNESS: mask = 32'h0000_00ff;
      REG_TIMEOUT_SELECT: mask = 32'h0000_0007;
      default:            mask = 32'h0000_ffff;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= (value & mask) | ($urandom() & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_BRIGHTNESS: cfg_max_level = value[7:0];
      REG_TIMEOUT_SELECT: cfg_timeout = value[2:0];
      default:            cfg_period = value[15:0];
    endcase
    @(negedge clk);
    reg_check(idx);
  endtask

  task automatic set_registers(input logic [7:0] max_level, input logic [2:0] timeout,
                               input logic [15:0] period);
    reg_write(REG_MAX_BRIGHTNESS, 32'(max_level));
    reg_write(REG_TIMEOUT_SELECT, 32'(timeout));
    reg_write(REG_PWM_PERIOD, 32'(period));
  endtask

  task automatic test_reset_values();
    reg_check(REG_MAX_BRIGHTNESS);
    reg_check(REG_TIMEOUT_SELECT);
    reg_check(REG_PWM_PERIOD);
  endtask

  // level extremes, every event, a whole fade-out and a fade from zero
  task automatic test_directed_events();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_event(OP_TICK, 8'hff);
    send_event(OP_SET, 8'd255);
    send_event(OP_SET, 8'd9);
    send_event(OP_ON, 8'h00);
    send_event(OP_OFF, 8'haa);
    repeat (20) send_event(OP_TICK, 8'($urandom()));
    send_event(OP_OFF, 8'h55);
    send_event(OP_TICK, 8'h00);
    wait_idle();
  endtask

  // register extremes, with maximum zero and timeout zero among them
  task automatic test_register_extremes();
    int i;
    for (i = 0; i < 4; i++) begin
      case (i)
        0: set_registers(8'd0, 3'd0, 16'd0);
        1: set_registers(8'd255, 3'd7, 16'd65535);
        2: set_registers(8'd9, 3'd6, 16'd65535);
        default: set_registers(8'd1, 3'd2, 16'd1);
      endcase
      gaps_on = (i % 2 == 1);
      stall_pct = 30 * i;
      send_event(OP_ON, 8'($urandom()));
      send_event(OP_TICK, 8'($urandom()));
      send_event(OP_SET, 8'd9);
      send_event(OP_SET, 8'd10);
      send_event(OP_OFF, 8'($urandom()));
      repeat (3) send_event(OP_TICK, 8'($urandom()));
      send_event(OP_ON, 8'($urandom()));
      send_event(OP_SET, 8'd0);
      wait_idle();
    end
  endtask

  // every countdown choice
  task automatic test_timeout_choices();
    int sel;
    gaps_on = 1'b1;
    stall_pct = 20;
    for (sel = 0; sel < 8; sel++) begin
      reg_write(REG_TIMEOUT_SELECT, 32'(sel));
      send_event(OP_ON, 8'($urandom()));
      send_event(OP_TICK, 8'($urandom()));
      send_event(OP_OFF, 8'($urandom()));
      send_event(OP_TICK, 8'($urandom()));
      wait_idle();
    end
  endtask

  // receiver holds off while events keep coming, so the block stalls its input
  task automatic test_backpressure();
    set_registers(8'd200, 3'd3, 16'd4000);
    gaps_on = 1'b0;
    stall_pct = 0;
    holdoff_req = 300;
    repeat (40) send_random_event();
    wait_idle();
  endtask

  // sender pauses until every expected result has come
  task automatic test_drain_pause();
    gaps_on = 1'b1;
    stall_pct = 40;
    repeat (3) begin
      repeat (10) send_random_event();
      wait_drained();
    end
    wait_idle();
  endtask

  // mostly on / off / fade sequences with random content, some noise
  task automatic test_random_traffic();
    int phase;
    int goal;
    int k;
    logic [7:0] max_level;
    logic [15:0] period;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: max_level = 8'd0;
        1: max_level = 8'd255;
        2: max_level = 8'($urandom_range(12, 1));
        default: max_level = 8'($urandom());
      endcase
      case ($urandom_range(3))
        0: period = 16'd0;
        1: period = 16'hffff;
        2: period = 16'd1023;
        default: period = 16'($urandom());
      endcase
      set_registers(max_level, 3'($urandom_range(7)), period);
      gaps_on = (phase % 3 != 0);
      stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(70);
      goal = events_sent + 100;
      while (events_sent < goal) begin
        if ($urandom_range(9) < 7) begin
          send_event(OP_ON, 8'($urandom()));
          repeat ($urandom_range(3)) send_event(OP_TICK, 8'($urandom()));
          if ($urandom_range(3) == 0) send_event(OP_SET, 8'($urandom()));
          send_event(OP_OFF, 8'($urandom()));
          k = $urandom_range(1) ? $urandom_range(24, 20) : $urandom_range(19);
          repeat (k) send_event(OP_TICK, 8'($urandom()));
          case ($urandom_range(3))
            0: send_event(OP_SET, 8'($urandom()));
            1: send_event(OP_ON, 8'($urandom()));
            default: ;
          endcase
        end else begin
          repeat ($urandom_range(5, 1)) send_random_event();
        end
      end
      wait_idle();
    end
  endtask

  // receiver stall pattern: runs of ready and not ready, plus requested hold-offs
  always @(negedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      res_if.ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stalled = ($urandom_range(99) < stall_pct);
        run_left = $urandom_range(6, 1);
      end
      run_left--;
      res_if.ready <= !run_stalled;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fails++;
      end else begin
        due = pending_results.pop_front();
        if (res_if.pwm_compare !== due.pwm_compare) begin
          $error("pwm_compare: expected %0d, actual %0d", due.pwm_compare, res_if.pwm_compare);
          fails++;
        end
        if (res_if.light_is_on !== due.light_is_on) begin
          $error("light_is_on: expected %0d, actual %0d", due.light_is_on, res_if.light_is_on);
          fails++;
        end
        if (res_if.level_now !== due.level_now) begin
          $error("level_now: expected %0d, actual %0d", due.level_now, res_if.level_now);
          fails++;
        end
        if (res_if.countdown_load !== due.countdown_load) begin
          $error("countdown_load: expected %0d, actual %0d", due.countdown_load,
                 res_if.countdown_load);
          fails++;
        end
        if (res_if.countdown_load_valid !== due.countdown_load_valid) begin
          $error("countdown_load_valid: expected %0d, actual %0d", due.countdown_load_valid,
                 res_if.countdown_load_valid);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ev_if.valid = 1'b0;
    ev_if.opcode = OP_TICK;
    ev_if.new_level = 8'd0;
    res_if.ready = 1'b0;
    cfg_max_level = MAX_BRIGHTNESS_RST;
    cfg_timeout = TIMEOUT_SELECT_RST;
    cfg_period = PWM_PERIOD_RST;
    fade_target = 8'd0;
    fade_origin = 8'd0;
    fade_pos = 5'd0;
    fading = 1'b0;
    level_applied = 8'd0;
    lamp_on = 1'b0;
    fails = 0;
    events_sent = 0;
    quiet_cycles = 0;
    gaps_on = 1'b0;
    offering = 1'b0;
    burst_left = 0;
    stall_pct = 0;
    holdoff_req = 0;
    holdoff_left = 0;
    run_left = 0;
    run_stalled = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_directed_events();
    test_register_extremes();
    test_timeout_choices();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ backlight_fade_controller.f @@
rtl/blf_pkg.sv
rtl/blf_if.sv
rtl/blf_regs.sv
rtl/blf_mul.sv
rtl/backlight_fade_controller.sv
tb/sv/testbench.sv
